// ----- rtl/core/pfi_pkg.sv -----
// Shared types and codes for the polyphase FIR interpolator.
// Request/response payloads, controller state, command/status structs.
// No dependencies.
package pfi_pkg;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_IDX_FACTOR = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDX_PHASE  = 4'd1;

   localparam int FACTOR_W = 4;
   localparam int PHASE_W  = 6;

   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 4'd1;
   localparam logic [PHASE_W-1:0]  PHASE_RESET  = 6'd1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_PUSH = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [7:0]         coeff_index;
      logic signed [15:0] coeff_value;
      logic signed [15:0] in_sample;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_sample;
      logic               last;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic push;
      logic issue;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic adv;
      logic tap_end;
      logic phase_end;
      logic no_phase;
   } status_type;

endpackage

// ----- rtl/core/polyphase_fir_interpolator.sv -----
// Polyphase FIR interpolator: top level with configuration registers.
// Depends on pfi_pkg, pfi_ctrl, pfi_datapath (and pfi_ram below it).
//
// Request channel (req_valid/req_stall/req_payload): cmd CMD_LOAD writes
// coeff_value at coeff_index of the coefficient store (indexes at or above
// MAX_FACTOR*MAX_PHASE_TAPS are dropped); cmd CMD_PUSH shifts in_sample into
// the delay line and produces L responses, phase L-1 down to phase 0, the
// final one carrying last.
// Response channel (rsp_valid/rsp_stall/rsp_payload) is fed from a single
// output register. While it is stalled and full, the MAC pipeline freezes.
// CSR channel: index 0 sets the interpolation factor L, index 1 the taps per
// phase P; csr_ready is always high. Write only while idle.
// Throughput: a push runs L*P taps on the single shared MAC, one tap per
// cycle while the output is not stalled (coefficient and delay RAM read in
// parallel); further requests stall until the last tap is issued.
// Reset clears L and P to 1 and empties the delay line (a fill count makes
// unpushed samples read as zero); coefficients are undefined until loaded.
module polyphase_fir_interpolator #(
   parameter int MAX_FACTOR     = 8,
   parameter int MAX_PHASE_TAPS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  pfi_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output pfi_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pfi_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pfi_pkg::CSR_DATA_W-1:0]       csr_data
);
   import pfi_pkg::*;

   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   cmd_type             cmd;
   status_type          status;

   assign csr_ready = 1'b1;

   always_comb begin
      factor_in = factor_ff;
      phase_in  = phase_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IDX_FACTOR: factor_in = csr_data[FACTOR_W-1:0];
            CSR_IDX_PHASE:  phase_in  = csr_data[PHASE_W-1:0];
            default: begin
               factor_in = factor_ff;
               phase_in  = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FACTOR_RESET;
         phase_ff  <= PHASE_RESET;
      end else begin
         factor_ff <= factor_in;
         phase_ff  <= phase_in;
      end
   end

   pfi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_payload.cmd),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pfi_datapath #(
      .MAX_FACTOR     (MAX_FACTOR),
      .MAX_PHASE_TAPS (MAX_PHASE_TAPS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg_factor  (factor_ff),
      .cfg_phase   (phase_ff),
      .req         (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- rtl/core/pfi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/pfi_ctrl.sv -----
// Sequencer for the interpolator: accepts requests and steps the shared
// MAC through every tap of every phase. Depends on pfi_pkg.
module pfi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_cmd,
   output logic                req_stall,
   input  pfi_pkg::status_type status,
   output pfi_pkg::cmd_type    cmd
);
   import pfi_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_cmd == CMD_PUSH && !status.no_phase) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.adv && status.tap_end && status.phase_end) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_LOAD: cmd.load = 1'b1;
                  CMD_PUSH: cmd.push = 1'b1;
                  default:  cmd      = '0;
               endcase
            end
         end
         ST_RUN: begin
            cmd.issue = status.adv;
         end
         default: req_stall = 1'b1;
      endcase
   end

   // a stalled output must freeze the tap sequence
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && !status.adv) |=> (state_ff == ST_RUN))
      else $error("sequencer left RUN while output was stalled");

endmodule

// ----- rtl/core/pfi_datapath.sv -----
// Datapath: coefficient store, circular delay line, one pipelined MAC,
// round/saturate and the output register. Depends on pfi_pkg, pfi_ram.
module pfi_datapath #(
   parameter int MAX_FACTOR     = 8,
   parameter int MAX_PHASE_TAPS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [3:0]          cfg_factor,
   input  logic [5:0]          cfg_phase,
   input  pfi_pkg::req_type    req,
   input  pfi_pkg::cmd_type    cmd,
   output pfi_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pfi_pkg::rsp_type    rsp_payload
);
   import pfi_pkg::*;

   localparam int STORE = MAX_FACTOR * MAX_PHASE_TAPS;
   localparam int CW = (STORE > 1) ? $clog2(STORE) : 1;
   localparam int DW = (MAX_PHASE_TAPS > 1) ? $clog2(MAX_PHASE_TAPS) : 1;
   localparam int PW = $clog2(MAX_PHASE_TAPS + 1);
   localparam int FW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
   localparam int LW = $clog2(MAX_FACTOR + 1);

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic last_phase;
      logic ok;
   } tag_type;

   function automatic rsp_type round_sat(input logic signed [39:0] acc,
                                         input logic last);
      logic signed [39:0] r;
      rsp_type            res;
      r        = acc + 40'sd16384;
      res.last = last;
      if (r >= 40'sd1073741824) begin
         res.out_sample = 16'sh7fff;
      end else if (r < -40'sd1073741824) begin
         res.out_sample = 16'sh8000;
      end else begin
         res.out_sample = r[30:15];
      end
      return res;
   endfunction

   // effective configuration
   logic [LW-1:0] l_eff;
   logic [PW-1:0] p_eff, pm1;

   always_comb begin
      l_eff = (32'(cfg_factor) > MAX_FACTOR) ? LW'(MAX_FACTOR) : LW'(cfg_factor);
      if (cfg_phase == 6'd0) begin
         p_eff = PW'(1);
      end else if (32'(cfg_phase) > MAX_PHASE_TAPS) begin
         p_eff = PW'(MAX_PHASE_TAPS);
      end else begin
         p_eff = PW'(cfg_phase);
      end
      pm1 = p_eff - PW'(1);
   end

   logic adv;
   logic out_valid_ff, out_valid_in;
   assign adv = !out_valid_ff || !rsp_stall;

   // address and tap counters
   logic [DW-1:0] wp_ff, wp_in, daddr_ff, daddr_in, d_rd_addr, d_start;
   logic [PW-1:0] fill_ff, fill_in, age_ff, age_in, age_cur;
   logic [CW-1:0] caddr_ff, caddr_in, c_rd_addr;
   logic [FW-1:0] phase_ff, phase_in;
   logic          first_ff, first_in;
   logic          tap_end;

   always_comb begin
      if (wp_ff >= DW'(pm1)) begin
         d_start = wp_ff - DW'(pm1);
      end else begin
         d_start = DW'((DW+1)'(wp_ff) + (DW+1)'(MAX_PHASE_TAPS) - (DW+1)'(pm1));
      end
      d_rd_addr = first_ff ? d_start : daddr_ff;
      c_rd_addr = first_ff ? CW'(phase_ff) : caddr_ff;
      age_cur   = first_ff ? pm1 : age_ff;
      tap_end   = (age_cur == '0);
   end

   always_comb begin
      wp_in    = wp_ff;
      fill_in  = fill_ff;
      daddr_in = daddr_ff;
      caddr_in = caddr_ff;
      age_in   = age_ff;
      phase_in = phase_ff;
      first_in = first_ff;
      if (cmd.push) begin
         wp_in    = (wp_ff == DW'(MAX_PHASE_TAPS - 1)) ? '0 : wp_ff + DW'(1);
         if (fill_ff != PW'(MAX_PHASE_TAPS)) begin
            fill_in = fill_ff + PW'(1);
         end
         phase_in = FW'(l_eff - LW'(1));
         first_in = 1'b1;
      end else if (cmd.issue) begin
         daddr_in = (d_rd_addr == DW'(MAX_PHASE_TAPS - 1)) ? '0 : d_rd_addr + DW'(1);
         caddr_in = c_rd_addr + CW'(l_eff);
         age_in   = age_cur - PW'(1);
         first_in = tap_end;
         if (tap_end) begin
            phase_in = phase_ff - FW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         fill_ff  <= '0;
         first_ff <= 1'b1;
      end else begin
         wp_ff    <= wp_in;
         fill_ff  <= fill_in;
         first_ff <= first_in;
      end
      daddr_ff <= daddr_in;
      caddr_ff <= caddr_in;
      age_ff   <= age_in;
      phase_ff <= phase_in;
   end

   assign status.adv       = adv;
   assign status.tap_end   = tap_end;
   assign status.phase_end = (phase_ff == '0);
   assign status.no_phase  = (l_eff == '0);

   // stores
   logic [15:0] coeff_rd, sample_rd;
   logic        coeff_we;
   assign coeff_we = cmd.load && (32'(req.coeff_index) < STORE);

   pfi_ram #(.WIDTH(16), .DEPTH(STORE)) u_coeff_ram (
      .clock   (clock),
      .wr_en   (coeff_we),
      .wr_addr (CW'(req.coeff_index)),
      .wr_data (req.coeff_value),
      .rd_en   (cmd.issue),
      .rd_addr (c_rd_addr),
      .rd_data (coeff_rd)
   );

   pfi_ram #(.WIDTH(16), .DEPTH(MAX_PHASE_TAPS)) u_delay_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (wp_in),
      .wr_data (req.in_sample),
      .rd_en   (cmd.issue),
      .rd_addr (d_rd_addr),
      .rd_data (sample_rd)
   );

   // MAC pipeline: read -> product -> accumulate -> round into output
   tag_type            s1_ff, s1_in, s2_ff, s2_in;
   logic signed [31:0] prod_ff, prod_in;
   logic signed [39:0] acc_ff, acc_in;
   logic               s3_valid_ff, s3_valid_in, s3_last_ff, s3_last_in;
   rsp_type            out_ff, out_in;

   always_comb begin
      s1_in            = s1_ff;
      s2_in            = s2_ff;
      prod_in          = prod_ff;
      acc_in           = acc_ff;
      s3_valid_in      = s3_valid_ff;
      s3_last_in       = s3_last_ff;
      out_valid_in     = out_valid_ff;
      out_in           = out_ff;
      if (adv) begin
         s1_in.valid      = cmd.issue;
         s1_in.first      = first_ff;
         s1_in.last       = tap_end;
         s1_in.last_phase = status.phase_end;
         // an age never pushed reads as zero
         s1_in.ok         = age_cur < fill_ff;
         s2_in            = s1_ff;
         prod_in          = s1_ff.ok ? $signed(sample_rd) * $signed(coeff_rd) : 32'sd0;
         if (s2_ff.valid) begin
            acc_in = (s2_ff.first ? 40'sd0 : acc_ff) + 40'(prod_ff);
         end
         s3_valid_in  = s2_ff.valid && s2_ff.last;
         s3_last_in   = s2_ff.last_phase;
         out_valid_in = s3_valid_ff;
         if (s3_valid_ff) begin
            out_in = round_sat(acc_ff, s3_last_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid  <= 1'b0;
         s2_ff.valid  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_ff.valid  <= s1_in.valid;
         s2_ff.valid  <= s2_in.valid;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_ff.first      <= s1_in.first;
      s1_ff.last       <= s1_in.last;
      s1_ff.last_phase <= s1_in.last_phase;
      s1_ff.ok         <= s1_in.ok;
      s2_ff.first      <= s2_in.first;
      s2_ff.last       <= s2_in.last;
      s2_ff.last_phase <= s2_in.last_phase;
      s2_ff.ok         <= s2_in.ok;
      prod_ff          <= prod_in;
      acc_ff           <= acc_in;
      s3_last_ff       <= s3_last_in;
      out_ff           <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= PW'(MAX_PHASE_TAPS))
      else $error("delay line fill count overran its depth");

   assert property (@(posedge clock) disable iff (reset)
      (adv && s2_ff.valid && s2_ff.last) |=> s3_valid_ff)
      else $error("finished phase sum did not reach the rounding stage");

   assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(acc_ff) && $stable(s2_ff) && $stable(s3_valid_ff)))
      else $error("MAC pipeline moved while the output was stalled");

endmodule

// ----- tb/sv/polyphase_fir_interpolator_checker.sv -----
// Response checker for the polyphase FIR interpolator testbench.
// Watches the request, response and CSR channels, predicts each response.
// Depends on pfi_pkg.
module polyphase_fir_interpolator_checker #(
   parameter int MAX_FACTOR     = 8,
   parameter int MAX_PHASE_TAPS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  pfi_pkg::req_type                  req_payload,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  pfi_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [pfi_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pfi_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                mismatch_count,
   output int                                results_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import pfi_pkg::*;

   localparam int STORE_DEPTH = MAX_FACTOR * MAX_PHASE_TAPS;

   logic [FACTOR_W-1:0] factor_reg;
   logic [PHASE_W-1:0]  phase_reg;
   // taps[0] is the newest sample
   logic signed [15:0]  taps [MAX_PHASE_TAPS];
   logic signed [15:0]  coeffs [STORE_DEPTH];
   rsp_type             expected_outputs [$];

   function automatic logic signed [15:0] round_saturate(input longint acc);
      longint r;
      r = acc + 64'sd16384;
      if (r >= (64'sd1 <<< 30))
         return 16'sh7FFF;
      if (r < -(64'sd1 <<< 30))
         return 16'sh8000;
      return 16'(r >>> 15);
   endfunction

   function automatic void interpolate_push(input logic signed [15:0] sample);
      int      l_eff;
      int      p_eff;
      longint  acc;
      rsp_type r;
      for (int j = MAX_PHASE_TAPS - 1; j > 0; j--)
         taps[j] = taps[j-1];
      taps[0] = sample;
      l_eff = (factor_reg > MAX_FACTOR) ? MAX_FACTOR : int'(factor_reg);
      p_eff = (phase_reg == 0) ? 1 :
              (phase_reg > MAX_PHASE_TAPS) ? MAX_PHASE_TAPS : int'(phase_reg);
      // phases go from L-1 down to 0; oldest sample meets the first tap
      for (int i = l_eff; i > 0; i--) begin
         acc = 0;
         for (int k = 0; k < p_eff; k++)
            acc += longint'(taps[p_eff-1-k]) * longint'(coeffs[(i-1) + k*l_eff]);
         r.out_sample = round_saturate(acc);
         r.last       = (i == 1);
         expected_outputs.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         factor_reg = FACTOR_RESET;
         phase_reg  = PHASE_RESET;
         foreach (taps[j]) taps[j] = '0;
         foreach (coeffs[j]) coeffs[j] = '0;
         expected_outputs.delete();
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IDX_FACTOR)
               factor_reg = csr_data[FACTOR_W-1:0];
            else if (csr_index == CSR_IDX_PHASE)
               phase_reg = csr_data[PHASE_W-1:0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_outputs.size() == 0) begin
               $error("unexpected response: out_sample %0d last %0b",
                      rsp_payload.out_sample, rsp_payload.last);
               mismatch_count++;
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_payload.out_sample !== want.out_sample) begin
                  $error("out_sample: expected %0d, got %0d",
                         want.out_sample, rsp_payload.out_sample);
                  mismatch_count++;
               end
               if (rsp_payload.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_payload.last);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_payload.cmd == CMD_LOAD) begin
               if (req_payload.coeff_index < STORE_DEPTH)
                  coeffs[req_payload.coeff_index] = req_payload.coeff_value;
            end else begin
               interpolate_push(req_payload.in_sample);
            end
         end
      end
      results_pending = expected_outputs.size();
   end

endmodule

// ----- tb/sv/polyphase_fir_interpolator_tb.sv -----
// Testbench top for the polyphase FIR interpolator: clock, reset, stimulus
// and verdict. Depends on pfi_pkg, polyphase_fir_interpolator and
// polyphase_fir_interpolator_checker.
module polyphase_fir_interpolator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pfi_pkg::*;

   localparam int MAX_FACTOR     = 8;
   localparam int MAX_PHASE_TAPS = 32;
   localparam int STORE_DEPTH    = MAX_FACTOR * MAX_PHASE_TAPS;
   localparam int SETTLE_CYCLES  = 300;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_ITEMS   = 30;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   req_type                 req_payload;
   logic                    rsp_valid;
   logic                    rsp_stall;
   rsp_type                 rsp_payload;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;
   int                      mismatch_count;
   int                      results_pending;

   int   send_gap_pct = 0;
   int   stall_pct = 0;
   logic hold_go;
   int   idle_cycles = 0;
   bit   coeff_written [STORE_DEPTH];

   polyphase_fir_interpolator #(
      .MAX_FACTOR     (MAX_FACTOR),
      .MAX_PHASE_TAPS (MAX_PHASE_TAPS)
   ) dut (.*);

   polyphase_fir_interpolator_checker #(
      .MAX_FACTOR     (MAX_FACTOR),
      .MAX_PHASE_TAPS (MAX_PHASE_TAPS)
   ) checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // response side: random stalls, plus one long hold-off once requested
   initial begin
      int held;
      held = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && held < HOLD_CYCLES) begin
            rsp_stall <= 1'b1;
            held++;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("polyphase_fir_interpolator_tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic signed [15:0] random_q15();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         default: return $signed(16'($urandom)) >>> $urandom_range(0, 6);
      endcase
   endfunction

   task automatic send_request(input req_type r);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_payload <= r;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic load_coeff(input logic [7:0] idx, input logic signed [15:0] value);
      req_type r;
      r.cmd         = CMD_LOAD;
      r.coeff_index = idx;
      r.coeff_value = value;
      r.in_sample   = 16'($urandom);
      coeff_written[idx] = 1'b1;
      send_request(r);
   endtask

   task automatic push_sample(input logic signed [15:0] sample);
      req_type r;
      r.cmd         = CMD_PUSH;
      r.coeff_index = 8'($urandom);
      r.coeff_value = 16'($urandom);
      r.in_sample   = sample;
      send_request(r);
   endtask

   // drain all responses, then let any response-free work finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   task automatic set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_gap_pct = 0;  stall_pct <= 0;  end
         IDLE_SENDER:   begin send_gap_pct = 48; stall_pct <= 0;  end
         IDLE_RECEIVER: begin send_gap_pct = 0;  stall_pct <= 48; end
         default:       begin send_gap_pct = 8;  stall_pct <= 8;  end
      endcase
   endtask

   // returns L*P in effect; loads any coefficient the new setting will read
   task automatic configure(input logic [FACTOR_W-1:0] f, input logic [PHASE_W-1:0] p,
                            output int used_taps);
      int l_eff;
      int p_eff;
      if ($urandom_range(0, 2) == 0)
         write_csr(CSR_INDEX_W'($urandom_range(2, 15)), CSR_DATA_W'($urandom));
      write_csr(CSR_IDX_FACTOR, {4'($urandom), f});
      write_csr(CSR_IDX_PHASE, {2'($urandom), p});
      csr_valid <= 1'b0;
      l_eff = (f > MAX_FACTOR) ? MAX_FACTOR : int'(f);
      p_eff = (p == 0) ? 1 : (p > MAX_PHASE_TAPS) ? MAX_PHASE_TAPS : int'(p);
      used_taps = l_eff * p_eff;
      for (int i = 0; i < used_taps; i++)
         if (!coeff_written[i])
            load_coeff(8'(i), random_q15());
   endtask

   initial begin
      int random_sent;
      int phase_idx;
      int n;
      int used_taps;
      logic [FACTOR_W-1:0] f;
      logic [PHASE_W-1:0]  p;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= '0;
      csr_data    <= '0;
      hold_go     <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting, one tap and one phase: rounding and saturation corners
      load_coeff(8'd0, 16'sh8000);
      push_sample(16'sh8000);
      push_sample(16'sh7FFF);
      load_coeff(8'd0, 16'sh7FFF);
      push_sample(16'sh7FFF);
      push_sample(16'sh8000);
      load_coeff(8'd0, 16'sd1);
      push_sample(16'sd16384);
      push_sample(-16'sd16384);
      push_sample(16'sd16383);
      push_sample(-16'sd16385);
      // loads outside L*P are still stored
      load_coeff(8'd255, random_q15());
      load_coeff(8'd200, random_q15());
      push_sample(16'sh0000);

      // factor zero: samples enter the delay line, nothing comes out
      wait_idle();
      set_idle_mode(IDLE_SENDER);
      configure(4'd0, 6'd5, used_taps);
      repeat (3) push_sample(random_q15());

      // factor above max and phase length zero are clamped
      wait_idle();
      set_idle_mode(IDLE_RECEIVER);
      configure(4'd15, 6'd0, used_taps);
      push_sample(16'sh7FFF);
      push_sample(16'sh8000);
      push_sample(random_q15());

      // largest setting, fills the whole store
      wait_idle();
      set_idle_mode(IDLE_BOTH);
      configure(4'd8, 6'd32, used_taps);
      push_sample(16'sh7FFF);
      push_sample(16'sh8000);
      push_sample(random_q15());

      // phase length above max, history kept across the change
      wait_idle();
      set_idle_mode(IDLE_NONE);
      configure(4'd2, 6'd63, used_taps);
      push_sample(random_q15());
      push_sample(random_q15());

      // long receiver hold-off while requests keep coming
      wait_idle();
      configure(4'd4, 6'd3, used_taps);
      hold_go <= 1'b1;
      repeat (12) push_sample(random_q15());

      random_sent = 0;
      phase_idx   = 0;
      while (random_sent < RANDOM_ITEMS) begin
         wait_idle();
         case ($urandom_range(0, 9))
            0:       f = 4'd0;
            1:       f = 4'($urandom_range(9, 15));
            default: f = 4'($urandom_range(1, 8));
         endcase
         case ($urandom_range(0, 9))
            0:       p = 6'd0;
            1:       p = 6'($urandom_range(33, 63));
            2:       p = 6'($urandom_range(7, 32));
            default: p = 6'($urandom_range(1, 6));
         endcase
         set_idle_mode(idle_mode_type'(phase_idx % 4));
         configure(f, p, used_taps);
         n = (used_taps > 64) ? 4 : $urandom_range(12, 30);
         repeat (n) begin
            if ($urandom_range(0, 6) == 0)
               load_coeff(8'($urandom), random_q15());
            else
               push_sample(random_q15());
            random_sent++;
         end
         phase_idx++;
      end

      wait_idle();
      if (results_pending != 0)
         $error("%0d expected responses never arrived", results_pending);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("polyphase_fir_interpolator_tb passed");
      end else begin
         $display("polyphase_fir_interpolator_tb failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/pfi_pkg.sv
rtl/core/pfi_ram.sv
rtl/core/pfi_ctrl.sv
rtl/core/pfi_datapath.sv
rtl/core/polyphase_fir_interpolator.sv
tb/sv/polyphase_fir_interpolator_checker.sv
tb/sv/polyphase_fir_interpolator_tb.sv
